>>> design/bq_pkg.sv
// bq_pkg: shared types and constants for the saturating biquad section.
// Holds the register index codes, the sequencer step and control types and
// the default widths. No dependencies.
`default_nettype none

package bq_pkg;

  localparam int SAMPLE_WIDTH        = 16;
  localparam int COEF_WIDTH          = 32;
  localparam int DEF_COEF_FRAC_BITS  = 28;
  localparam int DEF_STATE_WIDTH     = 56;

  // shared multiplier: 33-bit signed operand (a 32-bit slice plus sign)
  // times a 32-bit signed coefficient
  localparam int SLICE_WIDTH         = 32;
  localparam int MUL_A_WIDTH         = SLICE_WIDTH + 1;
  localparam int MUL_P_WIDTH         = MUL_A_WIDTH + COEF_WIDTH;

  localparam int REG_INDEX_WIDTH     = 3;

  // coef_b0 resets to 1.0 in Q3.28
  localparam logic [COEF_WIDTH-1:0] COEF_B0_RESET = 32'h1000_0000;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MOP_XIN,   // sample straight from the input port (accept cycle)
    MOP_X,     // latched sample
    MOP_YLO,   // low slice of y, zero extended
    MOP_YHI    // high slice of y, sign extended
  } mop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Y,
    ST_BX1,
    ST_A1L,
    ST_A1H,
    ST_T,
    ST_Z1,
    ST_A2H,
    ST_Z2
  } step_t;

  typedef struct packed {
    mop_t     mul_op;
    reg_idx_t mul_coef;
    logic     ld_y;
    logic     ld_bx;
    logic     ld_accw;
    logic     ld_ay;
    logic     ld_t;
    logic     ld_z1;
    logic     ld_z2;
    logic     ld_out;
  } ctrl_t;

endpackage

`default_nettype wire

>>> design/bq_mul.sv
// bq_mul: the shared signed 33x32 multiplier with a registered product.
// Uses bq_pkg for operand widths.
`default_nettype none

module bq_mul
  import bq_pkg::*;
(
  input  logic                          clk,
  input  logic signed [MUL_A_WIDTH-1:0] a,
  input  logic signed [COEF_WIDTH-1:0]  b,
  output logic signed [MUL_P_WIDTH-1:0] p
);

  // operands extend to the product width in this context, so p is exact
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

>>> design/bq_seq.sv
// bq_seq: step sequencer that drives the shared multiplier and the state
// registers of the biquad section. Uses bq_pkg (step_t, ctrl_t).
`default_nettype none

module bq_seq
  import bq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_free,
  output logic  in_ready,
  output ctrl_t ctrl
);

  step_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_Y;
      ST_Y:    state_next = ST_BX1;
      ST_BX1:  state_next = ST_A1L;
      ST_A1L:  state_next = ST_A1H;
      ST_A1H:  state_next = ST_T;
      ST_T:    state_next = ST_Z1;
      ST_Z1:   state_next = ST_A2H;
      ST_A2H:  state_next = ST_Z2;
      ST_Z2:   if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl          = '0;
    ctrl.mul_op   = MOP_X;
    ctrl.mul_coef = REG_B0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctrl.mul_op   = MOP_XIN;
        ctrl.mul_coef = REG_B0;
      end
      ST_Y: begin
        ctrl.ld_y     = 1'b1;
        ctrl.mul_coef = REG_B1;
      end
      ST_BX1: begin
        ctrl.ld_bx    = 1'b1;
        ctrl.mul_op   = MOP_YLO;
        ctrl.mul_coef = REG_A1;
      end
      ST_A1L: begin
        ctrl.ld_accw  = 1'b1;
        ctrl.mul_op   = MOP_YHI;
        ctrl.mul_coef = REG_A1;
      end
      ST_A1H: begin
        ctrl.ld_ay    = 1'b1;
        ctrl.mul_coef = REG_B2;
      end
      ST_T: begin
        ctrl.ld_t     = 1'b1;
        ctrl.ld_bx    = 1'b1;
        ctrl.mul_op   = MOP_YLO;
        ctrl.mul_coef = REG_A2;
      end
      ST_Z1: begin
        ctrl.ld_z1    = 1'b1;
        ctrl.ld_accw  = 1'b1;
        ctrl.mul_op   = MOP_YHI;
        ctrl.mul_coef = REG_A2;
      end
      ST_A2H: begin
        ctrl.ld_ay    = 1'b1;
      end
      ST_Z2: begin
        ctrl.ld_z2    = 1'b1;
        ctrl.ld_out   = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/biquad_iir_filter_saturating.sv
// biquad_iir_filter_saturating: second-order IIR section, transposed direct
// form II, saturating fixed point. Depends on bq_pkg, bq_mul, bq_seq.
//
//   channel | handshake          | word
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_ready  | sample_in (s16), last_in_block
//   out     | out_valid/out_ready| sample_out (s16), clipped, last_out
//   cfg     | cfg_we (no stall)  | cfg_index (3b), cfg_data (32b coef)
//
// Steps: after accept, a word passes through Y, BX1, A1L, A1H, T, Z1, A2H
//   and Z2; the next word is accepted in the cycle after the result
//   register loads, so no new word is taken while one is in flight. The steps
//   follow the seven passes through the single 33x32 multiplier (b0*x, b1*x,
//   b2*x and two slices each of a1*y and a2*y) plus the saturating add steps.
// Reset: rst (sync) clears the sequencer, both delay states and the result
//   valid flag, and loads the coefficients with b0 = 1.0, others zero.
// Stalls: a held result does not block input; the last step only waits if
//   the previous result is still unclaimed when the new one is ready.
`default_nettype none

module biquad_iir_filter_saturating
  import bq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int STATE_WIDTH    = DEF_STATE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // input words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  input  logic                             last_in_block,
  // result words
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
  output logic                             clipped,
  output logic                             last_out,
  // coefficient writes
  input  logic                             cfg_we,
  input  logic [REG_INDEX_WIDTH-1:0]       cfg_index,
  input  logic [COEF_WIDTH-1:0]            cfg_data
);

  // full-precision coef*y width, and the high slice of y
  localparam int PW = STATE_WIDTH + SLICE_WIDTH;
  localparam int HW = STATE_WIDTH - SLICE_WIDTH;

  localparam logic signed [STATE_WIDTH-1:0] SMAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] SMIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  // output clamp limits, 32767.0 and -32768.0 in the state format
  localparam logic signed [STATE_WIDTH-1:0] YTOP =
    STATE_WIDTH'(32767) << COEF_FRAC_BITS;
  localparam logic signed [STATE_WIDTH-1:0] YBOT =
    ~(STATE_WIDTH'(32768) << COEF_FRAC_BITS) + STATE_WIDTH'(1);
  localparam logic [STATE_WIDTH-1:0] FRAC_MASK =
    (STATE_WIDTH'(1) << COEF_FRAC_BITS) - STATE_WIDTH'(1);

  // ---------------------------------------------------------------------
  // saturating add / subtract on state-width values
  // ---------------------------------------------------------------------
  function automatic logic [STATE_WIDTH-1:0] sat_fix(input logic [STATE_WIDTH:0] s);
    if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) begin
      return s[STATE_WIDTH] ? SMIN : SMAX;
    end
    return s[STATE_WIDTH-1:0];
  endfunction

  function automatic logic [STATE_WIDTH-1:0] add_sat(input logic [STATE_WIDTH-1:0] a,
                                                     input logic [STATE_WIDTH-1:0] b);
    return sat_fix({a[STATE_WIDTH-1], a} + {b[STATE_WIDTH-1], b});
  endfunction

  function automatic logic [STATE_WIDTH-1:0] sub_sat(input logic [STATE_WIDTH-1:0] a,
                                                     input logic [STATE_WIDTH-1:0] b);
    return sat_fix({a[STATE_WIDTH-1], a} - {b[STATE_WIDTH-1], b});
  endfunction

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  logic signed [COEF_WIDTH-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic                           last;
  logic signed [STATE_WIDTH-1:0]  delay_one, delay_two;
  logic signed [STATE_WIDTH-1:0]  y;      // unclamped filter output
  logic signed [STATE_WIDTH-1:0]  bx;     // b1*x, then b2*x
  logic signed [STATE_WIDTH-1:0]  ay;     // a1*y, then a2*y, floored
  logic signed [STATE_WIDTH-1:0]  t;      // b1*x - a1*y
  logic signed [PW-1:0]           accw;   // low-slice partial of coef*y

  ctrl_t                          ctrl;
  logic                           out_free;
  logic signed [MUL_A_WIDTH-1:0]  mul_a;
  logic signed [COEF_WIDTH-1:0]   mul_b;
  logic signed [MUL_P_WIDTH-1:0]  prod;

  // ---------------------------------------------------------------------
  // sequencer and the shared multiplier
  // ---------------------------------------------------------------------
  assign out_free = !out_valid || out_ready;

  bq_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  always_comb begin
    case (ctrl.mul_op)
      MOP_XIN: mul_a = {{(MUL_A_WIDTH-SAMPLE_WIDTH){sample_in[SAMPLE_WIDTH-1]}}, sample_in};
      MOP_X:   mul_a = {{(MUL_A_WIDTH-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
      MOP_YLO: mul_a = {1'b0, y[SLICE_WIDTH-1:0]};
      MOP_YHI: mul_a = {{(MUL_A_WIDTH-HW){y[STATE_WIDTH-1]}}, y[STATE_WIDTH-1:SLICE_WIDTH]};
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.mul_coef)
      REG_B0:  mul_b = coef_b0;
      REG_B1:  mul_b = coef_b1;
      REG_B2:  mul_b = coef_b2;
      REG_A1:  mul_b = coef_a1;
      REG_A2:  mul_b = coef_a2;
      default: mul_b = coef_b0;
    endcase
  end

  bq_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // ---------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------
  // coef*x already sits in the state format and always fits
  logic [STATE_WIDTH-1:0] prod_lo;
  logic [PW-1:0]          prod_ext;
  logic [PW-1:0]          wide_sum;
  logic [PW-COEF_FRAC_BITS-STATE_WIDTH:0] wide_hi;
  logic                   wide_fits;
  logic [STATE_WIDTH-1:0] ay_next;

  assign prod_lo  = prod[STATE_WIDTH-1:0];
  assign prod_ext = {{(PW-MUL_P_WIDTH){prod[MUL_P_WIDTH-1]}}, prod};
  // high-slice partial lands 32 bits up; the value fits in STATE_WIDTH bits
  assign wide_sum = accw + {prod[STATE_WIDTH-1:0], {SLICE_WIDTH{1'b0}}};

  // floor by the fraction bits, then saturate to the state width
  assign wide_hi   = wide_sum[PW-1:COEF_FRAC_BITS+STATE_WIDTH-1];
  assign wide_fits = (&wide_hi) || !(|wide_hi);
  assign ay_next   = wide_fits ? wide_sum[COEF_FRAC_BITS+STATE_WIDTH-1:COEF_FRAC_BITS]
                               : (wide_sum[PW-1] ? SMIN : SMAX);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x    <= sample_in;
      last <= last_in_block;
    end
    if (ctrl.ld_y)    y    <= add_sat(prod_lo, delay_one);
    if (ctrl.ld_bx)   bx   <= prod_lo;
    if (ctrl.ld_accw) accw <= prod_ext;
    if (ctrl.ld_ay)   ay   <= ay_next;
    if (ctrl.ld_t)    t    <= sub_sat(bx, ay);
  end

  // delay states; a word marked last leaves them cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      if (ctrl.ld_z1) delay_one <= last ? '0 : add_sat(t, delay_two);
      if (ctrl.ld_z2) delay_two <= last ? '0 : sub_sat(bx, ay);
    end
  end

  // ---------------------------------------------------------------------
  // coefficient registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_B0_RESET;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_B0:  coef_b0 <= cfg_data;
        REG_B1:  coef_b1 <= cfg_data;
        REG_B2:  coef_b2 <= cfg_data;
        REG_A1:  coef_a1 <= cfg_data;
        REG_A2:  coef_a2 <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // output clamp and result register
  // ---------------------------------------------------------------------
  logic                   y_over, y_under;
  logic [STATE_WIDTH-1:0] y_rnd;

  assign y_over  = y > YTOP;
  assign y_under = y < YBOT;
  // bias negatives so the fraction drop truncates toward zero
  assign y_rnd   = y + (y[STATE_WIDTH-1] ? FRAC_MASK : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      last_out <= last;
      clipped  <= y_over || y_under;
      if (y_over) begin
        sample_out <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else if (y_under) begin
        sample_out <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
        sample_out <= y_rnd[COEF_FRAC_BITS+SAMPLE_WIDTH-1:COEF_FRAC_BITS];
      end
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a word is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.ld_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.ld_out |=> in_ready)
    else $error("sequencer did not return to idle after loading a result");

  a_last_clears_z1: assert property (@(posedge clk) disable iff (rst)
    ctrl.ld_z1 && last |=> delay_one == '0)
    else $error("delay_one not cleared after end-of-block word");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      sample_out == 16'sh7fff || sample_out == 16'sh8000)
    else $error("clipped word carries a value other than a rail");

endmodule

`default_nettype wire
